### rtl/core/ltc_pkg.sv
// shared types, constants and character helpers for the lexical token classifier
// no dependencies; used by ltc_token, ltc_out and lexical_token_classifier
package ltc_pkg;

    localparam int TOKEN_LEN_MAX_DEF = 255;
    localparam int LEN_W             = 8;
    localparam int PREFIX_DEPTH      = 5;
    localparam int PREFIX_IDX_W      = $clog2(PREFIX_DEPTH);

    typedef enum logic [2:0] {
        KIND_KEYWORD    = 3'd0,
        KIND_IDENTIFIER = 3'd1,
        KIND_OPERATOR   = 3'd2,
        KIND_NUMBER     = 3'd3,
        KIND_OTHER      = 3'd4,
        KIND_NEWLINE    = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [LEN_W-1:0]  length;
        logic              too_long;
        logic              last;
    } res_t;

    // up to two results caused by one item, first in order first
    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } pair_t;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    function automatic logic is_alpha_us(input logic [7:0] c);
        return (c == "_") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

endpackage

### rtl/core/ltc_token.sv
// pending-token state, delimiter detection and token classification
// depends on ltc_pkg
module ltc_token #(
    parameter int TOKEN_LEN_MAX = ltc_pkg::TOKEN_LEN_MAX_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           step_en,
    input  logic [7:0]     char_byte,
    input  logic           end_of_input,
    output ltc_pkg::pair_t pair
);
    import ltc_pkg::*;

    localparam int LenCapInt = (TOKEN_LEN_MAX > 255) ? 255 : TOKEN_LEN_MAX;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LenCapInt);

    logic [LEN_W-1:0] count_reg, count_next;
    logic             ident_reg, ident_next;
    logic             ovf_reg, ovf_next;
    logic [7:0]       prefix_reg [PREFIX_DEPTH];

    logic  delim, has_tok, is_nl;
    logic  kw_hit, op_hit;
    kind_t tok_kind;
    res_t  tok_res, nl_res;

    assign delim   = end_of_input || char_byte == CH_SPACE || char_byte == CH_NEWLINE;
    assign has_tok = count_reg != '0;
    assign is_nl   = !end_of_input && char_byte == CH_NEWLINE;

    // classification of the pending token
    always_comb begin
        kw_hit = (count_reg == LEN_W'(2) && prefix_reg[0] == "i" && prefix_reg[1] == "f")
              || (count_reg == LEN_W'(4) && prefix_reg[0] == "e" && prefix_reg[1] == "l"
                  && prefix_reg[2] == "s" && prefix_reg[3] == "e")
              || (count_reg == LEN_W'(5) && prefix_reg[0] == "p" && prefix_reg[1] == "r"
                  && prefix_reg[2] == "i" && prefix_reg[3] == "n" && prefix_reg[4] == "t");
        op_hit = (count_reg == LEN_W'(1) &&
                  (prefix_reg[0] == "+" || prefix_reg[0] == "-" || prefix_reg[0] == "*" ||
                   prefix_reg[0] == "/" || prefix_reg[0] == "%" || prefix_reg[0] == "=" ||
                   prefix_reg[0] == ">" || prefix_reg[0] == "<"))
              || (count_reg == LEN_W'(2) && prefix_reg[1] == "=" &&
                  (prefix_reg[0] == "=" || prefix_reg[0] == "!" ||
                   prefix_reg[0] == ">" || prefix_reg[0] == "<"));
        if (kw_hit) begin
            tok_kind = KIND_KEYWORD;
        end else if (ident_reg) begin
            tok_kind = KIND_IDENTIFIER;
        end else if (op_hit) begin
            tok_kind = KIND_OPERATOR;
        end else if (is_digit(prefix_reg[0])) begin
            tok_kind = KIND_NUMBER;
        end else begin
            tok_kind = KIND_OTHER;
        end
    end

    // results caused by this item
    always_comb begin
        tok_res.kind     = tok_kind;
        tok_res.length   = count_reg;
        tok_res.too_long = ovf_reg;
        tok_res.last     = !is_nl;
        nl_res.kind      = KIND_NEWLINE;
        nl_res.length    = '0;
        nl_res.too_long  = 1'b0;
        nl_res.last      = 1'b1;
        pair.count       = delim ? ({1'b0, has_tok} + {1'b0, is_nl}) : 2'd0;
        pair.first       = has_tok ? tok_res : nl_res;
        pair.second      = nl_res;
    end

    always_comb begin
        count_next = count_reg;
        ident_next = ident_reg;
        ovf_next   = ovf_reg;
        if (step_en) begin
            if (delim) begin
                if (has_tok) begin
                    count_next = '0;
                    ident_next = 1'b1;
                    ovf_next   = 1'b0;
                end
            end else begin
                if (!has_tok) begin
                    ident_next = is_alpha_us(char_byte);
                end else if (!(is_alpha_us(char_byte) || is_digit(char_byte))) begin
                    ident_next = 1'b0;
                end
                if (count_reg >= LEN_CAP) begin
                    ovf_next = 1'b1;
                end else begin
                    count_next = count_reg + LEN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ident_reg <= 1'b1;
            ovf_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            ident_reg <= ident_next;
            ovf_reg   <= ovf_next;
        end
    end

    // first characters of the token, only entries below the count are read
    always_ff @(posedge aclk) begin
        if (step_en && !delim && count_reg < LEN_W'(PREFIX_DEPTH)) begin
            prefix_reg[count_reg[PREFIX_IDX_W-1:0]] <= char_byte;
        end
    end

endmodule

### rtl/core/ltc_out.sv
// two-entry result buffer that hands results to the output channel in order
// depends on ltc_pkg
module ltc_out (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  ltc_pkg::pair_t pair,
    output logic           can_take,
    output logic           out_valid,
    input  logic           out_ready,
    output ltc_pkg::res_t  out_res
);
    import ltc_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    res_t       slot0_reg, slot0_next;
    res_t       slot1_reg, slot1_next;
    logic       pop;

    assign out_valid = cnt_reg != 2'd0;
    assign out_res   = slot0_reg;
    assign pop       = out_valid && out_ready;
    assign can_take  = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);

    always_comb begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (push) begin
            cnt_next   = pair.count;
            slot0_next = pair.first;
            slot1_next = pair.second;
        end else if (pop) begin
            cnt_next   = cnt_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

### rtl/core/lexical_token_classifier.sv
// top level of the lexical token classifier: input register, token logic, result buffer
// depends on ltc_pkg, ltc_token and ltc_out
//
// usage
//   slave channel: one character byte per item in s_tdata; s_tlast marks end of input,
//   which flushes the pending token (the byte is then ignored)
//   master channel: one classified token or newline per item; kind in m_tuser,
//   length and overflow flag in m_tdata, m_tlast on the final result of an input item
//   space and newline split tokens; a newline also gives a newline result
// datapath
//   an item is taken into the input register and classified combinationally from it;
//   its first result is registered in the result buffer that drives the master side
// throughput
//   one item per cycle while m_tready is high; a newline that closes a token gives two
//   results that fill the two-entry buffer and hold back the next item with a result
// reset
//   aresetn (synchronous, active low) empties the input and result registers and
//   drops any pending token
// stall
//   while m_tready is low, results wait in a two-entry buffer, the input register
//   holds one more item and s_tready falls only when both are occupied
module lexical_token_classifier #(
    parameter int TOKEN_LEN_MAX = ltc_pkg::TOKEN_LEN_MAX_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] char_byte
    input  logic        s_tlast,    // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] token_length, [8] too_long, [15:9] zero
    output logic [2:0]  m_tuser,    // [2:0] token_kind
    output logic        m_tlast     // last result of the input item
);
    import ltc_pkg::*;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_char_reg;
    logic       in_eoi_reg;

    pair_t pair;
    logic  can_take;
    logic  fire;
    logic  push;
    res_t  out_res;

    // an item that causes no result never waits for the buffer
    assign fire     = in_valid_reg && (pair.count == 2'd0 || can_take);
    assign push     = fire && pair.count != 2'd0;
    assign s_tready = !in_valid_reg || fire;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_eoi_reg  <= s_tlast;
        end
    end

    ltc_token #(
        .TOKEN_LEN_MAX (TOKEN_LEN_MAX)
    ) u_token (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (fire),
        .char_byte    (in_char_reg),
        .end_of_input (in_eoi_reg),
        .pair         (pair)
    );

    ltc_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pair      (pair),
        .can_take  (can_take),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {7'd0, out_res.too_long, out_res.length};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

    // a pair of results that is pushed must show a result on the master side
    a_pair_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        push && pair.count == 2'd2 |=> m_tvalid)
        else $error("second result of a pair lost");

    // input side stalls only while an item is held
    a_stall_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg)
        else $error("input stalled with empty input register");

    // newline results carry no length and no overflow and are marked last
    a_newline_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_NEWLINE |-> m_tdata[8:0] == 9'd0 && m_tlast)
        else $error("malformed newline result");

    // results appear only for items that were taken
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(push))
        else $error("result without a classified item");

endmodule
